/* rtl/bpe_pretokenizer_splitter_assert.svh */
// Assertion helpers shared by the splitter modules.
`ifndef BPE_PRETOKENIZER_SPLITTER_ASSERT_SVH
`define BPE_PRETOKENIZER_SPLITTER_ASSERT_SVH

// Checked only while out of reset.
`define BPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define BPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/bps_pkg.sv */
package bps_pkg;

  localparam int LOOKAHEAD = 2;
  localparam int MAX_RES   = LOOKAHEAD + 1;
  localparam int Q_DEPTH   = 8;
  localparam int PTR_W     = $clog2(Q_DEPTH);
  localparam int CNT_W     = PTR_W + 1;

  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_M     = 8'h6D;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_E     = 8'h65;
  localparam logic [7:0] HIGH_LETTER = 8'h80;

  typedef enum logic [2:0] {
    CL_NONE   = 3'd0,
    CL_CONTR  = 3'd1,
    CL_LETTER = 3'd2,
    CL_DIGIT  = 3'd3,
    CL_SYMBOL = 3'd4,
    CL_SPACE  = 3'd5
  } class_t;

  typedef struct packed {
    logic [7:0] data;
    logic       frag_end;
    logic       done;
  } entry_t;

  // Results of one input beat, written into the output queue together.
  typedef struct packed {
    logic [1:0]   cnt;
    entry_t [MAX_RES-1:0] ent;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic       e;
    class_t     cls;
    logic [1:0] left;
  } dec_t;

  function automatic class_t byte_class(logic [7:0] c);
    class_t r;
    if (c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D}) begin
      r = CL_SPACE;
    end else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
                 c >= HIGH_LETTER) begin
      r = CL_LETTER;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r = CL_DIGIT;
    end else begin
      r = CL_SYMBOL;
    end
    return r;
  endfunction

  // Flag of the front byte b0 given up to two bytes of lookahead (h1, h2 say
  // whether b1, b2 exist). ok low: more lookahead needed, nothing commits.
  function automatic dec_t decide(class_t cls, logic [1:0] left,
                                  logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                  logic h1, logic h2, logic eot);
    dec_t       d;
    class_t     c;
    logic [1:0] l;
    logic       e;
    logic       ok;
    c  = cls;
    l  = left;
    e  = 1'b0;
    ok = 1'b1;
    if (c == CL_NONE) begin
      if (b0 == CH_APOS) begin
        if (!h1 && !eot) ok = 1'b0;
        c = CL_SYMBOL;
        if (h1) begin
          if (b1 == CH_D || b1 == CH_S || b1 == CH_T || b1 == CH_M) begin
            c = CL_CONTR;
            l = 2'd1;
          end else if (b1 == CH_R || b1 == CH_V || b1 == CH_L) begin
            if (!h2 && !eot) ok = 1'b0;
            if (h2 && b2 == ((b1 == CH_L) ? CH_L : CH_E)) begin
              c = CL_CONTR;
              l = 2'd2;
            end
          end
        end
      end else if (b0 == CH_SPACE) begin
        if (!h1 && !eot) ok = 1'b0;
        c = CL_SPACE;
        if (h1 && byte_class(b1) != CL_SPACE) c = byte_class(b1);
      end else begin
        c = byte_class(b0);
      end
    end

    if (c == CL_CONTR) begin
      if (l == 2'd0) begin
        e = 1'b1;
      end else begin
        l = l - 2'd1;
      end
    end else if (c == CL_SPACE) begin
      // greedy run, but the last byte before non-space goes to the next run
      if (!h1) begin
        if (!eot) ok = 1'b0;
        e = 1'b1;
      end else if (byte_class(b1) != CL_SPACE) begin
        e = 1'b1;
      end else if (!h2) begin
        if (!eot) ok = 1'b0;
      end else begin
        e = byte_class(b2) != CL_SPACE;
      end
    end else begin
      if (!h1) begin
        if (!eot) ok = 1'b0;
        e = 1'b1;
      end else begin
        e = byte_class(b1) != c;
      end
    end

    if (e) begin
      c = CL_NONE;
      l = 2'd0;
    end
    d.ok   = ok;
    d.e    = e;
    d.cls  = c;
    d.left = l;
    return d;
  endfunction

endpackage

/* rtl/bps_out_queue.sv */
module bps_out_queue
  import bps_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  push_t  push,
  output logic   room,
  output logic   out_valid,
  input  logic   out_stall,
  output entry_t out_ent
);

  `include "bpe_pretokenizer_splitter_assert.svh"

  entry_t             mem_r [Q_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;

  assign out_valid = count_r != '0;
  assign out_ent   = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;
  // room for a full burst, ignoring a pop in the same cycle
  assign room      = count_r <= CNT_W'(Q_DEPTH - MAX_RES);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.cnt) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (j < int'(push.cnt)) begin
        mem_r[PTR_W'(wr_ptr_r + PTR_W'(j))] <= push.ent[j];
      end
    end
  end

  `BPS_ASSERT(a_q_no_overflow, (count_r <= CNT_W'(Q_DEPTH)), "output queue overflow")
  `BPS_ASSERT(a_q_push_shows, ((push.cnt != 2'd0) |=> (count_r != '0)), "pushed beat lost")
  `BPS_ASSERT(a_q_burst_fits, ((push.cnt != 2'd0) |-> room), "burst pushed without room")

endmodule

/* rtl/bpe_pretokenizer_splitter.sv */
// Pre-tokenizer splitter: tags each text byte with a fragment-end flag.
// Input channel: in_valid/in_stall with in_text_byte and in_end_of_text.
// A beat is taken when in_valid is high and in_stall low; one beat per cycle.
// Result channel: out_valid/out_stall with out_byte, out_fragment_end and
// out_text_done. Bytes leave in order, each once its flag is known, so a
// result may trail its input by up to two text bytes of lookahead; the
// end-of-text beat flushes all held bytes, the last one with out_text_done.
// Pipeline: input register, a combinational class and lookahead decision for
// up to three bytes, then an 8-entry output queue that every byte passes.
// Sustained rate is one byte per cycle unless the queue runs short of room;
// in_stall rises only while the queue lacks room for a three-byte flush,
// which the one-read-per-cycle queue sets. When the receiver stalls, results
// wait in the queue and input keeps being taken until that room runs out.
// Synchronous reset (rst_n low) empties the queue and input register and
// drops any open fragment and held bytes.
module bpe_pretokenizer_splitter
  import bps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_fragment_end,
  output logic       out_text_done
);

  `include "bpe_pretokenizer_splitter_assert.svh"

  logic       in_v_r;
  logic [7:0] in_byte_r;
  logic       in_eot_r;

  logic [7:0] held_r [LOOKAHEAD];
  logic [7:0] held_nxt [LOOKAHEAD];
  logic [1:0] hc_r, hc_nxt;
  class_t     cls_r, cls_nxt;
  logic [1:0] left_r, left_nxt;

  logic       room, adv;
  logic [7:0] w [MAX_RES];
  logic [1:0] n, k, rem;
  dec_t       st0, st1, st2;
  logic       ok0, ok1, ok2;
  push_t      push;
  entry_t     out_ent;

  assign adv      = in_v_r && room;
  assign in_stall = in_v_r && !room;

  always_comb begin
    n    = hc_r + 2'd1;
    w[0] = (hc_r == 2'd0) ? in_byte_r : held_r[0];
    w[1] = (hc_r == 2'd1) ? in_byte_r : held_r[1];
    w[2] = in_byte_r;

    st0 = decide(cls_r, left_r, w[0], w[1], w[2], n > 2'd1, n > 2'd2, in_eot_r);
    ok0 = st0.ok;
    st1 = decide(st0.cls, st0.left, w[1], w[2], 8'h00, n > 2'd2, 1'b0, in_eot_r);
    ok1 = ok0 && n > 2'd1 && st1.ok;
    st2 = decide(st1.cls, st1.left, w[2], 8'h00, 8'h00, 1'b0, 1'b0, in_eot_r);
    ok2 = ok1 && n > 2'd2 && st2.ok;

    k = ok2 ? 2'd3 : ok1 ? 2'd2 : ok0 ? 2'd1 : 2'd0;
    rem = n - k;

    push.cnt = adv ? k : 2'd0;
    push.ent[0] = '{data: w[0], frag_end: st0.e, done: in_eot_r && k == 2'd1};
    push.ent[1] = '{data: w[1], frag_end: st1.e, done: in_eot_r && k == 2'd2};
    push.ent[2] = '{data: w[2], frag_end: st2.e, done: in_eot_r && k == 2'd3};

    cls_nxt  = ok2 ? st2.cls  : ok1 ? st1.cls  : ok0 ? st0.cls  : cls_r;
    left_nxt = ok2 ? st2.left : ok1 ? st1.left : ok0 ? st0.left : left_r;

    held_nxt[0] = w[0];
    held_nxt[1] = w[1];
    case (k)
      2'd1: begin
        held_nxt[0] = w[1];
        held_nxt[1] = w[2];
      end
      2'd2: begin
        held_nxt[0] = w[2];
        held_nxt[1] = w[2];
      end
      default: begin
        held_nxt[0] = w[0];
        held_nxt[1] = w[1];
      end
    endcase
    hc_nxt = (rem == 2'd3) ? 2'd2 : rem;

    // end of text: every byte decided, back to the reset state
    if (in_eot_r) begin
      cls_nxt  = CL_NONE;
      left_nxt = 2'd0;
      hc_nxt   = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      hc_r   <= 2'd0;
      cls_r  <= CL_NONE;
      left_r <= 2'd0;
    end else begin
      if (!in_stall) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        hc_r   <= hc_nxt;
        cls_r  <= cls_nxt;
        left_r <= left_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_byte_r <= in_text_byte;
      in_eot_r  <= in_end_of_text;
    end
    if (adv) begin
      held_r[0] <= held_nxt[0];
      held_r[1] <= held_nxt[1];
    end
  end

  bps_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_ent   (out_ent)
  );

  assign out_byte         = out_ent.data;
  assign out_fragment_end = out_ent.frag_end;
  assign out_text_done    = out_ent.done;

  `BPS_ASSERT(a_hold_when_full, ((in_v_r && !room) |=> in_v_r), "stalled beat dropped")
  `BPS_ASSERT(a_eot_clears, ((adv && in_eot_r) |=> (hc_r == 2'd0 && cls_r == CL_NONE && left_r == 2'd0)), "flush left state")
  `BPS_ASSERT(a_held_bound, (hc_r != 2'd3), "held count beyond lookahead")

endmodule

/* bench/bpe_pretokenizer_splitter_test.sv */
module bpe_pretokenizer_splitter_test;
  import bps_pkg::*;

  localparam int unsigned HOLD_CYCLES = 80;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] chr;
    logic       closes;
    logic       last;
  } frag_beat_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_text_byte = 8'h00;
  logic       in_end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_fragment_end;
  logic       out_text_done;

  // splitter state as predicted
  logic [7:0] pend_bytes [0:1];
  int unsigned pend_cnt = 0;
  class_t     open_cls = CL_NONE;
  logic [1:0] contr_rem = 2'd0;

  frag_beat_t frags_due [$];
  logic [7:0] text_buf [$];
  int unsigned mismatch_count = 0;

  bit hold_req = 1'b0;
  bit rx_calm = 1'b0;
  bit tx_calm = 1'b0;

  bpe_pretokenizer_splitter dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_text_byte     (in_text_byte),
    .in_end_of_text   (in_end_of_text),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_fragment_end (out_fragment_end),
    .out_text_done    (out_text_done)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic class_t char_kind(input logic [7:0] ch);
    if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D)) return CL_SPACE;
    if (ch >= HIGH_LETTER || (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A))
      return CL_LETTER;
    if (ch >= 8'h30 && ch <= 8'h39) return CL_DIGIT;
    return CL_SYMBOL;
  endfunction

  // Flag for the front byte b0; returns 0 while more lookahead is needed.
  // Commits the open class only once the flag is known.
  function automatic bit settle_front(input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input int unsigned avail,
                                      input bit eot, output bit closes);
    class_t     c;
    logic [1:0] rem;
    bit         h1;
    bit         h2;
    bit         e;
    c = open_cls;
    rem = contr_rem;
    h1 = avail > 1;
    h2 = avail > 2;
    e = 1'b0;
    closes = 1'b0;
    if (c == CL_NONE) begin
      if (b0 == CH_APOS) begin
        if (!h1 && !eot) return 1'b0;
        c = CL_SYMBOL;
        if (h1) begin
          if (b1 == CH_D || b1 == CH_S || b1 == CH_T || b1 == CH_M) begin
            c = CL_CONTR;
            rem = 2'd1;
          end else if (b1 == CH_R || b1 == CH_V || b1 == CH_L) begin
            if (!h2 && !eot) return 1'b0;
            if (h2 && b2 == ((b1 == CH_L) ? CH_L : CH_E)) begin
              c = CL_CONTR;
              rem = 2'd2;
            end
          end
        end
      end else if (b0 == CH_SPACE) begin
        if (!h1 && !eot) return 1'b0;
        c = CL_SPACE;
        // a lone space becomes the prefix of the run that follows
        if (h1 && char_kind(b1) != CL_SPACE) c = char_kind(b1);
      end else begin
        c = char_kind(b0);
      end
    end
    case (c)
      CL_CONTR: begin
        if (rem == 2'd0) e = 1'b1;
        else rem = rem - 2'd1;
      end
      CL_SPACE: begin
        // the last space before non-space is handed to the next fragment
        if (!h1) begin
          if (!eot) return 1'b0;
          e = 1'b1;
        end else if (char_kind(b1) != CL_SPACE) begin
          e = 1'b1;
        end else if (!h2) begin
          if (!eot) return 1'b0;
        end else begin
          e = char_kind(b2) != CL_SPACE;
        end
      end
      default: begin
        if (!h1) begin
          if (!eot) return 1'b0;
          e = 1'b1;
        end else begin
          e = char_kind(b1) != c;
        end
      end
    endcase
    if (e) begin
      c = CL_NONE;
      rem = 2'd0;
    end
    open_cls = c;
    contr_rem = rem;
    closes = e;
    return 1'b1;
  endfunction

  task automatic predict_beat(input logic [7:0] b, input bit eot);
    logic [7:0]  win [0:4];
    frag_beat_t  got [0:2];
    int unsigned n;
    int unsigned pos;
    int unsigned k;
    bit          fe;
    for (int i = 0; i < 5; i++) win[i] = 8'h00;
    n = 0;
    for (int i = 0; i < pend_cnt; i++) begin
      win[n] = pend_bytes[i];
      n++;
    end
    win[n] = b;
    n++;
    pos = 0;
    k = 0;
    while (pos < n) begin
      if (!settle_front(win[pos], win[pos + 1], win[pos + 2], n - pos, eot, fe)) break;
      got[k] = '{chr: win[pos], closes: fe, last: 1'b0};
      k++;
      pos++;
    end
    if (eot) begin
      got[k - 1].last = 1'b1;
      pend_cnt = 0;
      open_cls = CL_NONE;
      contr_rem = 2'd0;
    end else begin
      pend_cnt = 0;
      for (int unsigned i = pos; i < n && pend_cnt < 2; i++) begin
        pend_bytes[pend_cnt] = win[i];
        pend_cnt++;
      end
    end
    for (int unsigned i = 0; i < k; i++) frags_due.insert(frags_due.size(), got[i]);
  endtask

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  task automatic send_byte(input logic [7:0] b, input bit eot);
    int unsigned gap;
    in_valid <= 1'b1;
    in_text_byte <= b;
    in_end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    predict_beat(b, eot);
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_text();
    for (int i = 0; i < text_buf.size(); i++)
      send_byte(text_buf[i], i == text_buf.size() - 1);
    text_buf.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (frags_due.size() != 0);
  endtask

  task automatic put_text(input logic [7:0] v);
    text_buf.insert(text_buf.size(), v);
  endtask

  task automatic add_str(input string s);
    for (int i = 0; i < s.len(); i++) put_text(s[i]);
  endtask

  function automatic logic [7:0] rand_of_kind(input class_t k);
    logic [7:0] v;
    do v = 8'($urandom_range(255)); while (char_kind(v) != k);
    return v;
  endfunction

  function automatic logic [7:0] rand_space();
    logic [7:0] v;
    v = 8'h09 + 8'($urandom_range(4));
    return ($urandom_range(99) < 60) ? CH_SPACE : v;
  endfunction

  task automatic add_piece();
    int unsigned r;
    int unsigned len;
    logic [7:0]  v;
    r = $urandom_range(99);
    if (r < 30) begin
      len = $urandom_range(1, 6);
      repeat (len) begin
        v = 8'h61 + 8'($urandom_range(25));
        put_text(($urandom_range(3) == 0) ? rand_of_kind(CL_LETTER) : v);
      end
    end else if (r < 40) begin
      len = $urandom_range(1, 4);
      repeat (len) put_text(rand_of_kind(CL_DIGIT));
    end else if (r < 52) begin
      len = $urandom_range(1, 3);
      repeat (len) put_text(rand_of_kind(CL_SYMBOL));
    end else if (r < 67) begin
      put_text(CH_APOS);
      case ($urandom_range(6))
        0: add_str("re");
        1: add_str("ve");
        2: add_str("ll");
        3: add_str("d");
        4: add_str("s");
        5: add_str("t");
        default: add_str("m");
      endcase
    end else if (r < 75) begin
      // apostrophe that does not make a contraction, or only almost does
      put_text(CH_APOS);
      case ($urandom_range(3))
        0: ;
        1: begin
          put_text(($urandom_range(2) == 0) ? CH_R :
                   ($urandom_range(1) == 0) ? CH_V : CH_L);
          v = 8'($urandom_range(255));
          put_text(v);
        end
        2: put_text(CH_E);
        default: add_str("S");
      endcase
    end else if (r < 90) begin
      len = $urandom_range(1, 4);
      repeat (len) put_text(rand_space());
    end else begin
      v = 8'($urandom_range(255));
      put_text(v);
    end
    if ($urandom_range(99) < 40) put_text(CH_SPACE);
  endtask

  task automatic build_text();
    int unsigned pieces;
    pieces = $urandom_range(1, 6);
    repeat (pieces) add_piece();
  endtask

  task automatic test_directed();
    // every contraction, the last one at end of text
    add_str("'re've'll'd's't'm");
    send_text();
    // apostrophe inside a symbol run, space prefixes, whitespace run giving up
    // its last space, apostrophe-r cut short by end of text
    put_text(8'h7F);
    add_str("'s ");
    put_text(8'hFF);
    put_text(8'h09);
    add_str("  5'r");
    send_text();
    // whitespace run that reaches end of text
    put_text(8'h0B);
    put_text(8'h0C);
    put_text(8'h0D);
    send_text();
  endtask

  task automatic test_steady_stream();
    int unsigned sent;
    rx_calm = 1'b1;
    tx_calm = 1'b1;
    sent = 0;
    while (sent < 40) begin
      build_text();
      sent += text_buf.size();
      send_text();
    end
    rx_calm = 1'b0;
    tx_calm = 1'b0;
  endtask

  task automatic test_random_text();
    int unsigned sent;
    int unsigned texts;
    sent = 0;
    texts = 0;
    while (sent < 220) begin
      build_text();
      sent += text_buf.size();
      send_text();
      texts++;
      if (texts % 6 == 0) wait_drained();
    end
  endtask

  task automatic test_backpressure();
    int unsigned sent;
    hold_req = 1'b1;
    tx_calm = 1'b1;
    sent = 0;
    while (sent < 40) begin
      build_text();
      sent += text_buf.size();
      send_text();
    end
    tx_calm = 1'b0;
    wait_drained();
  endtask

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : rx_throttle
    int unsigned stall_left;
    int unsigned hold_left;
    int unsigned r;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (!rx_calm) begin
        r = $urandom_range(99);
        if (r < 12) stall_left = $urandom_range(1, 3);
        else if (r < 15) stall_left = $urandom_range(10, 30);
      end
      out_stall <= (hold_left > 0) || (stall_left > 0);
    end
  end

  always @(posedge clk) begin : result_check
    frag_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (frags_due.size() == 0) begin
        $error("unexpected beat: out_byte %02h", out_byte);
        mismatch_count++;
      end else begin
        want = frags_due.pop_front();
        if (out_byte !== want.chr) begin
          $error("out_byte: expected %02h, got %02h", want.chr, out_byte);
          mismatch_count++;
        end
        if (out_fragment_end !== want.closes) begin
          $error("out_fragment_end: expected %0b, got %0b", want.closes, out_fragment_end);
          mismatch_count++;
        end
        if (out_text_done !== want.last) begin
          $error("out_text_done: expected %0b, got %0b", want.last, out_text_done);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_steady_stream();
    test_random_text();
    test_backpressure();
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && frags_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/bps_pkg.sv
rtl/bps_out_queue.sv
rtl/bpe_pretokenizer_splitter.sv
bench/bpe_pretokenizer_splitter_test.sv
